/* src/hqsc_pkg.sv */
// Package for the helicity quad sequence checker.
// Holds the error codes, quad position constants and the shared sync-bit struct.
// No dependencies.
package hqsc_pkg;

  localparam int unsigned SLOT_BITS_DEF = 8;
  localparam int unsigned POS_BITS      = 3;

  // Position value after reset, until a first-quad mark is seen
  localparam logic [POS_BITS-1:0] QUAD_POS_UNSYNC = 3'd5;
  localparam logic [POS_BITS-1:0] QUAD_POS_FIRST  = 3'd0;
  localparam logic [POS_BITS-1:0] QUAD_POS_SECOND = 3'd1;
  localparam logic [POS_BITS-1:0] QUAD_POS_THIRD  = 3'd2;
  localparam logic [POS_BITS-1:0] QUAD_POS_FOURTH = 3'd3;

  typedef enum logic [3:0] {
    ERR_NONE          = 4'd0,
    ERR_UNEXP_FIRST   = 4'd1,
    ERR_UNEXP_OTHER   = 4'd2,
    ERR_HEL_PREDICT   = 4'd3,
    ERR_PS_QS_MISMATCH = 4'd4,
    ERR_PS_SAME       = 4'd5,
    ERR_HEL_SAME      = 4'd6,
    ERR_HEL_CHANGED   = 4'd7,
    ERR_MID_PS        = 4'd8,
    ERR_MID_QS        = 4'd9,
    ERR_MID_HEL       = 4'd10
  } err_code_t;

  typedef struct packed {
    logic predict_ok;
    logic helicity;
    logic quad_sync;
    logic pair_sync;
  } sync_bits_t;

endpackage

/* src/hqsc_check.sv */
// Window and quad state of the helicity quad sequence checker, plus the
// per-event error decision. Depends on hqsc_pkg.
module hqsc_check import hqsc_pkg::*; #(
  parameter int unsigned SLOT_BITS = SLOT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [SLOT_BITS-1:0] slot,
  input  sync_bits_t           bits,
  output err_code_t            code
);

  logic [SLOT_BITS-1:0] prev_slot_r;
  logic [POS_BITS-1:0]  quad_pos_r, quad_pos_nxt;
  logic                 cur_valid_r, cur_pair_r, cur_quad_r, cur_hel_r;

  logic                 new_win;
  logic [POS_BITS-1:0]  pos_inc;
  logic                 pos_odd;

  assign new_win = (slot == SLOT_BITS'(1)) || (slot <= prev_slot_r);
  // (pos + 1) mod 4 only looks at the two low bits
  assign pos_inc = {1'b0, quad_pos_r[1:0] + 2'd1};

  always_comb begin
    code         = ERR_NONE;
    quad_pos_nxt = quad_pos_r;
    pos_odd      = 1'b0;
    if (new_win) begin
      if (!bits.quad_sync && quad_pos_r == QUAD_POS_UNSYNC) begin
        quad_pos_nxt = QUAD_POS_FIRST;
      end else begin
        quad_pos_nxt = pos_inc;
        if (!bits.quad_sync && pos_inc != QUAD_POS_FIRST) begin
          code         = ERR_UNEXP_FIRST;
          quad_pos_nxt = QUAD_POS_FIRST;
        end else if (bits.quad_sync && pos_inc == QUAD_POS_FIRST) begin
          code = ERR_UNEXP_OTHER;
        end
      end

      pos_odd = (quad_pos_nxt == QUAD_POS_SECOND) || (quad_pos_nxt == QUAD_POS_FOURTH);

      if (quad_pos_nxt == QUAD_POS_FIRST && !bits.predict_ok) begin
        code = ERR_HEL_PREDICT;
      end
      if (((quad_pos_nxt == QUAD_POS_FIRST || quad_pos_nxt == QUAD_POS_THIRD) &&
           bits.pair_sync) || (pos_odd && !bits.pair_sync)) begin
        code = ERR_PS_QS_MISMATCH;
      end
      // the window now closing becomes the previous one
      if (cur_valid_r) begin
        if (bits.pair_sync == cur_pair_r) begin
          code = ERR_PS_SAME;
        end
        if (pos_odd) begin
          if (bits.helicity == cur_hel_r) begin
            code = ERR_HEL_SAME;
          end
        end else if (quad_pos_nxt == QUAD_POS_THIRD) begin
          if (bits.helicity != cur_hel_r) begin
            code = ERR_HEL_CHANGED;
          end
        end
      end
    end else if (cur_valid_r) begin
      if (bits.pair_sync != cur_pair_r) begin
        code = ERR_MID_PS;
      end
      if (bits.quad_sync != cur_quad_r) begin
        code = ERR_MID_QS;
      end
      if (bits.helicity != cur_hel_r) begin
        code = ERR_MID_HEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_slot_r  <= '0;
      quad_pos_r   <= QUAD_POS_UNSYNC;
      cur_valid_r  <= 1'b0;
      cur_pair_r   <= 1'b0;
      cur_quad_r   <= 1'b0;
      cur_hel_r    <= 1'b0;
    end else if (step) begin
      prev_slot_r <= slot;
      if (new_win) begin
        quad_pos_r   <= quad_pos_nxt;
        cur_valid_r  <= 1'b1;
        cur_pair_r   <= bits.pair_sync;
        cur_quad_r   <= bits.quad_sync;
        cur_hel_r    <= bits.helicity;
      end
    end
  end

endmodule

/* src/helicity_quad_sequence_checker.sv */
// Helicity quad sequence checker, top level: input register, check logic, result register.
// Each input transfer passes the input register, then the result register to out_tdata.
// Throughput: one event per cycle unless out_tready stalls, set by the single-pass check.
// Reset (rst_n low, synchronous) empties both registers, sets the quad position to
// unsynchronised and forgets all stored windows.
// Depends on hqsc_pkg and hqsc_check.
module helicity_quad_sequence_checker import hqsc_pkg::*; #(
  parameter int unsigned SLOT_BITS = SLOT_BITS_DEF,
  localparam int unsigned IN_W     = ((SLOT_BITS + 4 + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // time_slot, pair_sync, quad_sync, helicity, helicity_predict_ok; zero fill above
  input  logic [IN_W-1:0] in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  // error_code [3:0]; zero fill above
  output logic [7:0]      out_tdata
);

  logic                 s1_valid_r;
  logic [SLOT_BITS-1:0] s1_slot_r;
  sync_bits_t           s1_bits_r;
  logic                 out_valid_r;
  err_code_t            out_code_r;
  err_code_t            code;
  logic                 advance, s1_move, in_take;

  assign advance   = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_slot_r            <= in_tdata[SLOT_BITS-1:0];
      s1_bits_r.pair_sync  <= in_tdata[SLOT_BITS];
      s1_bits_r.quad_sync  <= in_tdata[SLOT_BITS+1];
      s1_bits_r.helicity   <= in_tdata[SLOT_BITS+2];
      s1_bits_r.predict_ok <= in_tdata[SLOT_BITS+3];
    end
    if (s1_move) begin
      out_code_r <= code;
    end
  end

  hqsc_check #(
    .SLOT_BITS(SLOT_BITS)
  ) u_check (
    .clk  (clk),
    .rst_n(rst_n),
    .step (s1_move),
    .slot (s1_slot_r),
    .bits (s1_bits_r),
    .code (code)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_code_r};

endmodule
